/* rtl/core/assert_macros.svh */
// Assertion helpers. Both expect clk_i in scope; ASSERT_RST also expects rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ANY(lbl, prop, msg)
`endif

`endif

/* rtl/core/tcw_pkg.sv */
package tcw_pkg;

  localparam int CMD_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int CUR_W   = 11;
  localparam int GUARD_W = 7;
  localparam int CFG_W   = 8;
  localparam int CELL_W  = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0]  CHR_NEWLINE     = 8'd10;
  localparam logic [CHAR_W-1:0]  CHR_SPACE       = 8'd32;
  localparam logic [ATTR_W-1:0]  ATTR_RESET      = 8'd15;
  localparam logic [GUARD_W-1:0] GUARD_RESET     = 7'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT       = 3'd0,
    CMD_NEWLINE   = 3'd1,
    CMD_BACKSPACE = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_READ      = 3'd4
  } cmd_e;

  typedef enum logic [0:0] {
    REG_DEFAULT_ATTR = 1'b0,
    REG_PROMPT_GUARD = 1'b1
  } reg_e;

endpackage

/* rtl/core/tcw_req_if.sv */
interface tcw_req_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::CMD_W-1:0]  cmd;
  logic [tcw_pkg::CHAR_W-1:0] character;
  logic [tcw_pkg::ATTR_W-1:0] color;
  logic [tcw_pkg::IDX_W-1:0]  cell_index;

  modport source (output valid, output cmd, output character, output color,
                  output cell_index, input ready);
  modport sink   (input valid, input cmd, input character, input color,
                  input cell_index, output ready);
endinterface

/* rtl/core/tcw_rsp_if.sv */
interface tcw_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::CUR_W-1:0]  cursor_cell;
  logic [tcw_pkg::CHAR_W-1:0] read_char;
  logic [tcw_pkg::ATTR_W-1:0] read_attr;
  logic                       scrolled;

  modport source (output valid, output cursor_cell, output read_char,
                  output read_attr, output scrolled, input ready);
  modport sink   (input valid, input cursor_cell, input read_char,
                  input read_attr, input scrolled, output ready);
endinterface

/* rtl/core/text_console_writer_top.sv */
// Text console writer: a ROWS x COLS cell store (char in the low byte, attribute in the high
// byte) with a cursor. Each command beat yields one response beat. Put char, newline without
// scroll, backspace, unknown codes and out-of-range reads answer in the cycle after the beat is
// taken; a read of a cell answers after the registered read port and the READ state. A scroll
// (newline past the end, or put char with the cursor at the end) and a clear sweep the whole
// cell store, because every cell moves through the single write port of the cell store, one per
// cycle. No new command is taken while one is in progress. The cell store holds no reset value:
// issue a clear before reading cells that were never written.
`include "assert_macros.svh"

module text_console_writer_top #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tcw_req_if.sink                   req_i,
  tcw_rsp_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [tcw_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int CELLS = ROWS * COLS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int COLW  = $clog2(COLS);

  localparam logic [CW-1:0]   CELLS_C    = CW'(CELLS);
  localparam logic [CW-1:0]   COLS_C     = CW'(COLS);
  localparam logic [CW:0]     CELLS_X    = (CW+1)'(CELLS);
  localparam logic [CW:0]     COLS_X     = (CW+1)'(COLS);
  localparam logic [AW-1:0]   LAST_A     = AW'(CELLS - 1);
  localparam logic [AW-1:0]   COPY_END_A = AW'(CELLS - COLS);
  localparam logic [AW-1:0]   COLS_A     = AW'(COLS);
  localparam logic [COLW-1:0] COL_LAST   = COLW'(COLS - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_COPY  = 6'b000010,
    ST_BLANK = 6'b000100,
    ST_FIN   = 6'b001000,
    ST_CLEAR = 6'b010000,
    ST_READ  = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [CW-1:0]                 cursor_q, cursor_d;
  logic [COLW-1:0]               col_q, col_d;
  logic [AW-1:0]                 ptr_q, ptr_d;
  logic                          pend_q, pend_d;
  logic [AW-1:0]                 wa_q, wa_d;
  logic                          scr_q, scr_d;
  logic                          put_q;
  logic [tcw_pkg::CHAR_W-1:0]    pch_q;
  logic [tcw_pkg::ATTR_W-1:0]    pcol_q;
  logic [tcw_pkg::ATTR_W-1:0]    attr_q;
  logic [tcw_pkg::GUARD_W-1:0]   guard_q;

  logic                          ovld_q;
  logic [tcw_pkg::CUR_W-1:0]     ocur_q;
  logic [tcw_pkg::CHAR_W-1:0]    ochar_q;
  logic [tcw_pkg::ATTR_W-1:0]    oattr_q;
  logic                          oscr_q;

  logic                          accept;
  logic                          done;
  logic [tcw_pkg::CHAR_W-1:0]    rd_char;
  logic [tcw_pkg::ATTR_W-1:0]    rd_attr;
  logic [CW:0]                   nl_nxt;
  logic                          at_end;
  logic                          idx_ok;
  logic [tcw_pkg::CELL_W-1:0]    blank;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]    ram_rdata;

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE) && (!ovld_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign blank       = {attr_q, tcw_pkg::CHR_SPACE};
  // start of the next row: cursor - col + COLS
  assign nl_nxt      = {1'b0, cursor_q} - (CW+1)'(col_q) + COLS_X;
  assign at_end      = (cursor_q == CELLS_C);
  assign idx_ok      = (32'(req_i.cell_index) < 32'(CELLS));

  always_comb begin
    state_d   = state_q;
    cursor_d  = cursor_q;
    col_d     = col_q;
    ptr_d     = ptr_q;
    pend_d    = 1'b0;
    wa_d      = wa_q;
    scr_d     = scr_q;
    done      = 1'b0;
    rd_char   = '0;
    rd_attr   = '0;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = blank;
    ram_re    = 1'b0;
    ram_raddr = AW'(req_i.cell_index);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scr_d = 1'b0;
          case (tcw_pkg::cmd_e'(req_i.cmd))
            tcw_pkg::CMD_PUT: begin
              if (at_end) begin
                // scroll first, the character lands in FIN
                scr_d    = 1'b1;
                cursor_d = CELLS_C - COLS_C;
                col_d    = '0;
                ptr_d    = '0;
                state_d  = ST_COPY;
              end else if (req_i.character == tcw_pkg::CHR_NEWLINE) begin
                cursor_d = CW'(nl_nxt);
                col_d    = '0;
                done     = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cursor_q);
                ram_wdata = {req_i.color, req_i.character};
                cursor_d  = cursor_q + CW'(1);
                col_d     = (col_q == COL_LAST) ? '0 : col_q + COLW'(1);
                done      = 1'b1;
              end
            end
            tcw_pkg::CMD_NEWLINE: begin
              col_d = '0;
              if (nl_nxt >= CELLS_X) begin
                scr_d    = 1'b1;
                cursor_d = CW'(nl_nxt - COLS_X);
                ptr_d    = '0;
                state_d  = ST_COPY;
              end else begin
                cursor_d = CW'(nl_nxt);
                done     = 1'b1;
              end
            end
            tcw_pkg::CMD_BACKSPACE: begin
              // col > guard implies col > 0, so the cursor is inside a row
              if (32'(col_q) > 32'(guard_q)) begin
                cursor_d  = cursor_q - CW'(1);
                col_d     = col_q - COLW'(1);
                ram_we    = 1'b1;
                ram_waddr = AW'(cursor_q - CW'(1));
                ram_wdata = blank;
              end
              done = 1'b1;
            end
            tcw_pkg::CMD_CLEAR: begin
              cursor_d = '0;
              col_d    = '0;
              ptr_d    = '0;
              state_d  = ST_CLEAR;
            end
            tcw_pkg::CMD_READ: begin
              if (idx_ok) begin
                ram_re  = 1'b1;
                state_d = ST_READ;
              end else begin
                done = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      ST_COPY: begin
        // read cell i+COLS while the previous read lands at i-1
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata;
        end
        if (ptr_q != COPY_END_A) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + COLS_A;
          pend_d    = 1'b1;
          wa_d      = ptr_q;
          ptr_d     = ptr_q + AW'(1);
        end else begin
          state_d = ST_BLANK;
        end
      end

      ST_BLANK: begin
        ram_we = 1'b1;
        if (ptr_q == LAST_A) begin
          state_d = ST_FIN;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end

      ST_FIN: begin
        if (put_q) begin
          if (pch_q == tcw_pkg::CHR_NEWLINE) begin
            cursor_d = CW'(nl_nxt);
            col_d    = '0;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = AW'(cursor_q);
            ram_wdata = {pcol_q, pch_q};
            cursor_d  = cursor_q + CW'(1);
            col_d     = col_q + COLW'(1);
          end
        end
        done    = 1'b1;
        state_d = ST_IDLE;
      end

      ST_CLEAR: begin
        ram_we = 1'b1;
        if (ptr_q == LAST_A) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end

      ST_READ: begin
        rd_char = ram_rdata[tcw_pkg::CHAR_W-1:0];
        rd_attr = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        done    = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cursor_q <= '0;
      col_q    <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      scr_q    <= 1'b0;
      put_q    <= 1'b0;
      ovld_q   <= 1'b0;
      attr_q   <= tcw_pkg::ATTR_RESET;
      guard_q  <= tcw_pkg::GUARD_RESET;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      scr_q    <= scr_d;
      if (accept) begin
        put_q <= (req_i.cmd == tcw_pkg::CMD_PUT);
      end
      if (done) begin
        ovld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (tcw_pkg::reg_e'(cfg_idx_i))
          tcw_pkg::REG_DEFAULT_ATTR: attr_q  <= cfg_data_i;
          tcw_pkg::REG_PROMPT_GUARD: guard_q <= cfg_data_i[tcw_pkg::GUARD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q <= wa_d;
    if (accept) begin
      pch_q  <= req_i.character;
      pcol_q <= req_i.color;
    end
    if (done) begin
      ocur_q  <= tcw_pkg::CUR_W'(cursor_d);
      ochar_q <= rd_char;
      oattr_q <= rd_attr;
      oscr_q  <= scr_d;
    end
  end

  assign rsp_o.valid       = ovld_q;
  assign rsp_o.cursor_cell = ocur_q;
  assign rsp_o.read_char   = ochar_q;
  assign rsp_o.read_attr   = oattr_q;
  assign rsp_o.scrolled    = oscr_q;

  `ASSERT_ANY(a_cursor_range, cursor_q <= CELLS_C, "cursor past screen end")
  `ASSERT_RST(a_col_range, col_q <= COL_LAST, "column out of range")
  `ASSERT_RST(a_end_col_zero, !at_end || (col_q == '0), "cursor at end with nonzero column")
  `ASSERT_RST(a_ready_idle, !req_i.ready || (state_q == ST_IDLE), "ready while busy")
  `ASSERT_RST(a_clear_seq, (accept && (req_i.cmd == tcw_pkg::CMD_CLEAR)) |=> (state_q == ST_CLEAR), "clear did not start sweep")

endmodule

/* rtl/core/tcw_cell_ram.sv */
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [tcw_pkg::CELL_W-1:0] rdata_o
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
